### hw/rtl/tlb_page_table_cache_lookup_top_macros.svh
// ----------------------------------------------------------------------------
// TLB / page table / cache lookup: assertion macros
// Shared property forms for the lookup block checks.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_CACHE_LOOKUP_TOP_MACROS_SVH
`define TLB_PAGE_TABLE_CACHE_LOOKUP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TPC_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TPC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/tlbptc_pkg.sv
// ----------------------------------------------------------------------------
// TLB / page table / cache lookup package
// Request and result types, mode and status codes, default table sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbptc_pkg;

    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int PAGE_ENTRIES_DEF = 16;
    localparam int CACHE_LINES_DEF  = 16;

    // scan counter holds the largest table size
    localparam int CNT_W = 9;

    localparam logic [1:0] MODE_LOAD_TLB  = 2'd0;
    localparam logic [1:0] MODE_LOAD_PAGE = 2'd1;
    localparam logic [1:0] MODE_LOAD_LINE = 2'd2;
    localparam logic [1:0] MODE_LOOKUP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [7:0]  entry_tag;
        logic [3:0]  entry_set;
        logic [7:0]  entry_page;
        logic [7:0]  line_byte0;
        logic [7:0]  line_byte1;
        logic [7:0]  line_byte2;
        logic [7:0]  line_byte3;
        logic [13:0] virtual_address;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       tlb_hit;
        logic [7:0] physical_page;
        logic [7:0] data_byte;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/tlb_page_table_cache_lookup_top.sv
// ----------------------------------------------------------------------------
// TLB / page table / cache lookup
// Translates a 14-bit virtual address and reads one byte from a small cache.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load requests write
// one slot of their table in the cycle they are taken and return nothing;
// busy stays low. A lookup reads the three tables through their single
// memory ports, one entry per cycle: the TLB scan reads every TLB entry, a
// TLB miss adds a scan of the page table, and the cache scan stops at the
// first matching line or after the last line. The result appears in the
// first cycle with busy low, for exactly one cycle with done high; it cannot
// be held off, so capture it then.
`default_nettype none

`include "tlb_page_table_cache_lookup_top_macros.svh"

module tlb_page_table_cache_lookup_top #(
    parameter int TLB_ENTRIES  = tlbptc_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_ENTRIES = tlbptc_pkg::PAGE_ENTRIES_DEF,
    parameter int CACHE_LINES  = tlbptc_pkg::CACHE_LINES_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire tlbptc_pkg::req_t    req,
    output logic                     busy,
    output logic                     done,
    output tlbptc_pkg::result_t      result
);

    localparam int TAW = (TLB_ENTRIES  > 1) ? $clog2(TLB_ENTRIES)  : 1;
    localparam int PAW = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
    localparam int LAW = (CACHE_LINES  > 1) ? $clog2(CACHE_LINES)  : 1;
    localparam int CW  = tlbptc_pkg::CNT_W;

    localparam logic [CW-1:0] TLB_N  = CW'(TLB_ENTRIES);
    localparam logic [CW-1:0] PAGE_N = CW'(PAGE_ENTRIES);
    localparam logic [CW-1:0] LINE_N = CW'(CACHE_LINES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TLB  = 2'd1;
    localparam logic [1:0] S_PAGE = 2'd2;
    localparam logic [1:0] S_LINE = 2'd3;

    typedef struct packed {
        logic [7:0] tag;
        logic [3:0] set;
        logic [7:0] page;
    } tlb_entry_t;

    typedef struct packed {
        logic [7:0] vpage;
        logic [7:0] page;
    } page_entry_t;

    typedef struct packed {
        logic [3:0]      set;
        logic [7:0]      tag;
        logic [3:0][7:0] data;
    } line_entry_t;

    // table memories
    tlb_entry_t  tlb_mem  [TLB_ENTRIES];
    page_entry_t page_mem [PAGE_ENTRIES];
    line_entry_t line_mem [CACHE_LINES];

    tlb_entry_t  tlb_rd_reg;
    page_entry_t page_rd_reg;
    line_entry_t line_rd_reg;

    logic [TLB_ENTRIES-1:0]  tlb_valid_reg;
    logic [PAGE_ENTRIES-1:0] page_valid_reg;
    logic [CACHE_LINES-1:0]  line_valid_reg;
    logic                    tlb_vq_reg;
    logic                    page_vq_reg;
    logic                    line_vq_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [13:0]   va_reg, va_next;
    logic          found_reg, found_next;
    logic          from_tlb_reg, from_tlb_next;
    logic [7:0]    page_reg, page_next;
    logic          done_reg, done_next;
    tlbptc_pkg::result_t result_reg, result_next;

    logic          accept;
    logic [CW-1:0] slot_ext;
    logic          we_tlb, we_page, we_line;
    logic          re_tlb, re_page, re_line;
    logic          tlb_match, page_match, line_match;
    logic          cmp_live;
    tlb_entry_t    tlb_wdata;
    page_entry_t   page_wdata;
    line_entry_t   line_wdata;

    assign accept   = start && !busy;
    assign slot_ext = CW'(req.slot);

    assign we_tlb  = accept && (req.mode == tlbptc_pkg::MODE_LOAD_TLB)  && (slot_ext < TLB_N);
    assign we_page = accept && (req.mode == tlbptc_pkg::MODE_LOAD_PAGE) && (slot_ext < PAGE_N);
    assign we_line = accept && (req.mode == tlbptc_pkg::MODE_LOAD_LINE) && (slot_ext < LINE_N);

    assign tlb_wdata  = '{tag: req.entry_tag, set: req.entry_set, page: req.entry_page};
    assign page_wdata = '{vpage: req.entry_tag, page: req.entry_page};
    assign line_wdata = '{set: req.entry_set, tag: req.entry_tag,
                          data: {req.line_byte3, req.line_byte2,
                                 req.line_byte1, req.line_byte0}};

    assign re_tlb  = (state_reg == S_TLB)  && (cnt_reg < TLB_N);
    assign re_page = (state_reg == S_PAGE) && (cnt_reg < PAGE_N);
    assign re_line = (state_reg == S_LINE) && (cnt_reg < LINE_N);

    always_ff @(posedge clk)
    begin
        if (we_tlb)
        begin
            tlb_mem[slot_ext[TAW-1:0]] <= tlb_wdata;
        end
        if (re_tlb)
        begin
            tlb_rd_reg <= tlb_mem[cnt_reg[TAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_page)
        begin
            page_mem[slot_ext[PAW-1:0]] <= page_wdata;
        end
        if (re_page)
        begin
            page_rd_reg <= page_mem[cnt_reg[PAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_line)
        begin
            line_mem[slot_ext[LAW-1:0]] <= line_wdata;
        end
        if (re_line)
        begin
            line_rd_reg <= line_mem[cnt_reg[LAW-1:0]];
        end
    end

    // valid bits, sampled alongside each memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg  <= '0;
            page_valid_reg <= '0;
            line_valid_reg <= '0;
            tlb_vq_reg     <= 1'b0;
            page_vq_reg    <= 1'b0;
            line_vq_reg    <= 1'b0;
        end
        else
        begin
            if (we_tlb)
            begin
                tlb_valid_reg[slot_ext[TAW-1:0]] <= 1'b1;
            end
            if (we_page)
            begin
                page_valid_reg[slot_ext[PAW-1:0]] <= 1'b1;
            end
            if (we_line)
            begin
                line_valid_reg[slot_ext[LAW-1:0]] <= 1'b1;
            end
            if (re_tlb)
            begin
                tlb_vq_reg <= tlb_valid_reg[cnt_reg[TAW-1:0]];
            end
            if (re_page)
            begin
                page_vq_reg <= page_valid_reg[cnt_reg[PAW-1:0]];
            end
            if (re_line)
            begin
                line_vq_reg <= line_valid_reg[cnt_reg[LAW-1:0]];
            end
        end
    end

    // read data of entry cnt-1 is present whenever cnt is nonzero
    assign cmp_live = (cnt_reg != '0);

    assign tlb_match = cmp_live && tlb_vq_reg
                       && (tlb_rd_reg.tag == {2'b00, va_reg[13:8]})
                       && (tlb_rd_reg.set == {2'b00, va_reg[7:6]});
    assign page_match = cmp_live && page_vq_reg && (page_rd_reg.vpage == va_reg[13:6]);
    assign line_match = cmp_live && line_vq_reg
                        && (line_rd_reg.set == va_reg[5:2])
                        && (line_rd_reg.tag == page_reg);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        va_next       = va_reg;
        found_next    = found_reg;
        from_tlb_next = from_tlb_reg;
        page_next     = page_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.mode == tlbptc_pkg::MODE_LOOKUP))
                begin
                    state_next    = S_TLB;
                    cnt_next      = '0;
                    va_next       = req.virtual_address;
                    found_next    = 1'b0;
                    from_tlb_next = 1'b0;
                    page_next     = '0;
                end
            end
            S_TLB:
            begin
                // last match wins
                if (tlb_match)
                begin
                    found_next    = 1'b1;
                    from_tlb_next = 1'b1;
                    page_next     = tlb_rd_reg.page;
                end
                if (cnt_reg == TLB_N)
                begin
                    cnt_next   = '0;
                    state_next = (tlb_match || found_reg) ? S_LINE : S_PAGE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_PAGE:
            begin
                if (page_match)
                begin
                    found_next = 1'b1;
                    page_next  = page_rd_reg.page;
                end
                if (cnt_reg == PAGE_N)
                begin
                    cnt_next = '0;
                    if (page_match || found_reg)
                    begin
                        state_next = S_LINE;
                    end
                    else
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        result_next = '{status: tlbptc_pkg::ST_FAULT, tlb_hit: 1'b0,
                                        physical_page: 8'd0, data_byte: 8'd0};
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_LINE:
            begin
                // first match wins, scan stops there
                if (line_match)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{status: tlbptc_pkg::ST_OK, tlb_hit: from_tlb_reg,
                                    physical_page: page_reg,
                                    data_byte: line_rd_reg.data[va_reg[1:0]]};
                end
                else if (cnt_reg == LINE_N)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{status: tlbptc_pkg::ST_MISS, tlb_hit: from_tlb_reg,
                                    physical_page: page_reg, data_byte: 8'd0};
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        va_reg       <= va_next;
        found_reg    <= found_next;
        from_tlb_reg <= from_tlb_next;
        page_reg     <= page_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `TPC_ASSERT_SAME(a_done_follows_busy, done, $past(busy),
                     "result without a lookup")
    `TPC_ASSERT_SAME(a_fault_zero, done && (result.status == tlbptc_pkg::ST_FAULT),
                     (result.tlb_hit == 1'b0) && (result.physical_page == 8'd0)
                     && (result.data_byte == 8'd0),
                     "fault result carries nonzero fields")
    `TPC_ASSERT_SAME(a_miss_zero_byte, done && (result.status == tlbptc_pkg::ST_MISS),
                     result.data_byte == 8'd0, "cache miss returned a byte")
    `TPC_ASSERT_NEXT(a_lookup_busy,
                     start && !busy && (req.mode == tlbptc_pkg::MODE_LOOKUP),
                     busy && !done, "lookup request did not start a scan")

endmodule

`default_nettype wire
